>>> hw/rtl/ntc_pkg.sv
`default_nettype none
package ntc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int RES_W    = 22;
    localparam int MAG_W    = 7;
    localparam int POS_LEN  = 126;
    localparam int NEG_LEN  = 55;
    localparam logic [RES_W-1:0] POS_LIMIT = 22'd3211;
    localparam logic [RES_W-1:0] NEG_LIMIT = 22'd3379;
    localparam logic [2:0] REG_DISCARD = 3'd0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_code;
        logic [RES_W-1:0]    resistance_tens_ohms;
        logic [MAG_W-1:0]    temperature_magnitude;
        logic                below_zero;
    } result_t;

    function automatic logic [16:0] pos_res(input logic [6:0] i);
        logic [16:0] v;
        begin
            unique case (i)
                7'd0: v = 17'd3212;     7'd1: v = 17'd3060;     7'd2: v = 17'd2913;
                7'd3: v = 17'd2773;     7'd4: v = 17'd2641;     7'd5: v = 17'd2515;
                7'd6: v = 17'd2396;     7'd7: v = 17'd2283;     7'd8: v = 17'd2176;
                7'd9: v = 17'd2075;     7'd10: v = 17'd1978;    7'd11: v = 17'd1887;
                7'd12: v = 17'd1800;    7'd13: v = 17'd1718;    7'd14: v = 17'd1640;
                7'd15: v = 17'd1565;    7'd16: v = 17'd1495;    7'd17: v = 17'd1428;
                7'd18: v = 17'd1364;    7'd19: v = 17'd1304;    7'd20: v = 17'd1246;
                7'd21: v = 17'd1192;    7'd22: v = 17'd1140;    7'd23: v = 17'd1090;
                7'd24: v = 17'd1043;    7'd25: v = 17'd1000;    7'd26: v = 17'd956;
                7'd27: v = 17'd915;     7'd28: v = 17'd877;     7'd29: v = 17'd840;
                7'd30: v = 17'd805;     7'd31: v = 17'd771;     7'd32: v = 17'd739;
                7'd33: v = 17'd709;     7'd34: v = 17'd680;     7'd35: v = 17'd652;
                7'd36: v = 17'd626;     7'd37: v = 17'd601;     7'd38: v = 17'd577;
                7'd39: v = 17'd554;     7'd40: v = 17'd532;     7'd41: v = 17'd511;
                7'd42: v = 17'd491;     7'd43: v = 17'd472;     7'd44: v = 17'd453;
                7'd45: v = 17'd436;     7'd46: v = 17'd419;     7'd47: v = 17'd403;
                7'd48: v = 17'd388;     7'd49: v = 17'd373;     7'd50: v = 17'd359;
                7'd51: v = 17'd345;     7'd52: v = 17'd332;     7'd53: v = 17'd320;
                7'd54: v = 17'd308;     7'd55: v = 17'd297;     7'd56: v = 17'd286;
                7'd57: v = 17'd275;     7'd58: v = 17'd265;     7'd59: v = 17'd256;
                7'd60: v = 17'd247;     7'd61: v = 17'd238;     7'd62: v = 17'd229;
                7'd63: v = 17'd221;     7'd64: v = 17'd213;     7'd65: v = 17'd206;
                7'd66: v = 17'd199;     7'd67: v = 17'd192;     7'd68: v = 17'd185;
                7'd69: v = 17'd179;     7'd70: v = 17'd173;     7'd71: v = 17'd167;
                7'd72: v = 17'd161;     7'd73: v = 17'd156;     7'd74: v = 17'd150;
                7'd75: v = 17'd145;     7'd76: v = 17'd140;     7'd77: v = 17'd136;
                7'd78: v = 17'd131;     7'd79: v = 17'd127;     7'd80: v = 17'd123;
                7'd81: v = 17'd119;     7'd82: v = 17'd115;     7'd83: v = 17'd111;
                7'd84: v = 17'd108;     7'd85: v = 17'd104;     7'd86: v = 17'd101;
                7'd87: v = 17'd98;      7'd88: v = 17'd95;      7'd89: v = 17'd92;
                7'd90: v = 17'd89;      7'd91: v = 17'd86;      7'd92: v = 17'd84;
                7'd93: v = 17'd81;      7'd94: v = 17'd79;      7'd95: v = 17'd76;
                7'd96: v = 17'd74;      7'd97: v = 17'd72;      7'd98: v = 17'd70;
                7'd99: v = 17'd68;      7'd100: v = 17'd66;     7'd101: v = 17'd64;
                7'd102: v = 17'd62;     7'd103: v = 17'd60;     7'd104: v = 17'd58;
                7'd105: v = 17'd57;     7'd106: v = 17'd55;     7'd107: v = 17'd54;
                7'd108: v = 17'd52;     7'd109: v = 17'd51;     7'd110: v = 17'd49;
                7'd111: v = 17'd48;     7'd112: v = 17'd46;     7'd113: v = 17'd45;
                7'd114: v = 17'd44;     7'd115: v = 17'd43;     7'd116: v = 17'd42;
                7'd117: v = 17'd40;     7'd118: v = 17'd39;     7'd119: v = 17'd38;
                7'd120: v = 17'd37;     7'd121: v = 17'd36;     7'd122: v = 17'd35;
                7'd123: v = 17'd34;     7'd124: v = 17'd33;     7'd125: v = 17'd32;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [16:0] neg_res(input logic [5:0] i);
        logic [16:0] v;
        begin
            unique case (i)
                6'd0: v = 17'd3380;     6'd1: v = 17'd3552;     6'd2: v = 17'd3735;
                6'd3: v = 17'd3927;     6'd4: v = 17'd4131;     6'd5: v = 17'd4345;
                6'd6: v = 17'd4571;     6'd7: v = 17'd4810;     6'd8: v = 17'd5062;
                6'd9: v = 17'd5328;     6'd10: v = 17'd5609;    6'd11: v = 17'd5902;
                6'd12: v = 17'd6218;    6'd13: v = 17'd6549;    6'd14: v = 17'd6898;
                6'd15: v = 17'd7267;    6'd16: v = 17'd7657;    6'd17: v = 17'd8070;
                6'd18: v = 17'd8506;    6'd19: v = 17'd8968;    6'd20: v = 17'd9457;
                6'd21: v = 17'd9976;    6'd22: v = 17'd10525;   6'd23: v = 17'd11108;
                6'd24: v = 17'd11728;   6'd25: v = 17'd12387;   6'd26: v = 17'd13088;
                6'd27: v = 17'd13835;   6'd28: v = 17'd14632;   6'd29: v = 17'd15483;
                6'd30: v = 17'd16393;   6'd31: v = 17'd17368;   6'd32: v = 17'd18414;
                6'd33: v = 17'd19537;   6'd34: v = 17'd20745;   6'd35: v = 17'd22047;
                6'd36: v = 17'd23450;   6'd37: v = 17'd24965;   6'd38: v = 17'd26602;
                6'd39: v = 17'd28373;   6'd40: v = 17'd30289;   6'd41: v = 17'd32362;
                6'd42: v = 17'd34605;   6'd43: v = 17'd37028;   6'd44: v = 17'd39643;
                6'd45: v = 17'd42455;   6'd46: v = 17'd45470;   6'd47: v = 17'd48686;
                6'd48: v = 17'd52091;   6'd49: v = 17'd55664;   6'd50: v = 17'd59369;
                6'd51: v = 17'd63147;   6'd52: v = 17'd66917;   6'd53: v = 17'd70566;
                6'd54: v = 17'd73950;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ntc_adc_to_temperature.sv
`default_nettype none
// From the transfer that completes a group to m_tvalid: the shared restoring divider first forms
// the average and then the resistance. When the resistance lies between the tables the result goes
// out directly; else the chosen table is walked, one table entry per cycle.
// Throughput: samples that do not finish a group are taken one per cycle; after the last one
// s_tready stays low until the result transfer.
// Reset (rst_n, asynchronous, active low) sets discard_samples to 1 and empties the group.
module ntc_adc_to_temperature
#(
    parameter int AVG_SAMPLES = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB-style configuration port, one register at address 0.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input samples. tdata: adc_sample[11:0], zero padded.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // Results. tdata: average_code[11:0], resistance_tens_ohms[33:12],
    // temperature_magnitude[40:34], below_zero[41], zero padded.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata
);
    import ntc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_AVG  = 6'b000010,
        ST_RES  = 6'b000100,
        ST_RWT  = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  disc_reg, disc_next;
    logic [15:0] sum_reg, sum_next;
    logic [4:0]  pos_reg, pos_next;
    logic [6:0]  idx_reg, idx_next;
    result_t     res_reg, res_next;

    logic        div_start, div_busy, div_done;
    logic [21:0] div_a, div_q;
    logic [12:0] div_b;
    logic        cfg_wr, in_acc;
    logic [4:0]  pos_inc;
    logic [4:0]  avg_seen;
    logic [16:0] pv, pv_prev, nv, nv_prev;

    localparam logic [4:0] AVG_N = 5'(AVG_SAMPLES);

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_DISCARD) ? {28'd0, disc_reg} : 32'd0;
    assign cfg_wr   = psel && penable && pwrite && (paddr == REG_DISCARD);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, res_reg.below_zero, res_reg.temperature_magnitude,
                       res_reg.resistance_tens_ohms, res_reg.average_code};
    assign pos_inc  = pos_reg + 5'd1;
    assign avg_seen = pos_inc - {1'b0, disc_reg};

    assign pv      = pos_res(idx_reg);
    assign pv_prev = pos_res(idx_reg - 7'd1);
    assign nv      = neg_res(idx_reg[5:0]);
    assign nv_prev = neg_res(idx_reg[5:0] - 6'd1);

    ntc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        disc_next  = disc_reg;
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        div_a      = {6'd0, sum_reg};
        div_b      = 13'(AVG_SAMPLES);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    pos_next = pos_inc;
                    if (pos_reg >= {1'b0, disc_reg})
                    begin
                        sum_next = sum_reg + {4'd0, s_tdata[11:0]};
                        if (avg_seen >= AVG_N)
                        begin
                            div_start  = 1'b1;
                            div_a      = {6'd0, sum_next};
                            state_next = ST_AVG;
                        end
                    end
                end
            end
            ST_AVG:
            begin
                if (div_done)
                begin
                    res_next.average_code = div_q[11:0];
                    div_start  = 1'b1;
                    // 1000*avg as 1024*avg - 16*avg - 8*avg.
                    div_a      = {div_q[11:0], 10'd0} - {6'd0, div_q[11:0], 4'd0}
                                 - {7'd0, div_q[11:0], 3'd0};
                    div_b      = 13'h1000 - {1'b0, div_q[11:0]};
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (div_done)
                begin
                    res_next.resistance_tens_ohms  = div_q;
                    res_next.temperature_magnitude = '0;
                    res_next.below_zero = (div_q > NEG_LIMIT);
                    idx_next = 7'd1;
                    if (div_q < POS_LIMIT || div_q > NEG_LIMIT)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                // Walk the chosen table one entry per cycle; the last match wins.
                if (!res_reg.below_zero)
                begin
                    if (res_reg.resistance_tens_ohms >= {5'd0, pv}
                        && res_reg.resistance_tens_ohms < {5'd0, pv_prev})
                        res_next.temperature_magnitude = idx_reg + 7'd1;
                    if (idx_reg == 7'(POS_LEN - 1))
                        state_next = ST_OUT;
                end
                else
                begin
                    if (res_reg.resistance_tens_ohms >= {5'd0, nv_prev}
                        && res_reg.resistance_tens_ohms < {5'd0, nv})
                        res_next.temperature_magnitude = idx_reg;
                    if (idx_reg == 7'(NEG_LEN - 1))
                        state_next = ST_OUT;
                end
                idx_next = idx_reg + 7'd1;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    sum_next   = '0;
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            disc_next = pwdata[3:0];
            sum_next  = '0;
            pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            disc_reg  <= 4'd1;
            sum_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            disc_reg  <= disc_next;
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    // The divider's busy flag is covered by the sequencer's own states.
    logic unused_busy;
    assign unused_busy = div_busy;
endmodule
`default_nettype wire

>>> hw/rtl/ntc_divider.sv
`default_nettype none
module ntc_divider
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [21:0] dividend,
    input  wire logic [12:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [21:0]      quotient
);
    // Restoring division, one quotient bit per cycle, MSB first.
    logic [21:0] quot_reg, quot_next;
    logic [12:0] rem_reg, rem_next;
    logic [12:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [13:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[21]} - {1'b0, dvs_reg};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 5'd21;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[13])
            begin
                rem_next  = trial[12:0];
                quot_next = {quot_reg[20:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[11:0], quot_reg[21]};
                quot_next = {quot_reg[20:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule
`default_nettype wire
